// ----- design/ppc_pkg.sv -----
package ppc_pkg;

  // Number of CORDIC micro-rotations, one cell each (8 to 24).
  localparam int NumStages = 16;
  // Fraction bits of the position fields. Only the unit depends on it.
  localparam int PosFracBits = 8;

  localparam int PosW = 32;
  localparam int HeadW = 16;
  localparam int VecW = PosW + 1;          // difference of two positions
  localparam int AngInW = HeadW + 1;       // a negated heading reaches +pi
  localparam int GuardBits = 8;
  localparam int CordW = 44;               // gained, guarded vector plus growth
  localparam int AngW = 33;                // residual angle, pi = 2^31
  localparam int ProdW = 64;
  localparam int GainShift = 30 - GuardBits;
  localparam int AtanIdxW = 5;
  localparam int SumW = CordW - GuardBits + 1;

  localparam logic signed [30:0] GainQ30 = 31'sd652032874;
  localparam logic signed [AngInW-1:0] QuarterTurn = 17'sd16384;
  localparam logic signed [AngInW-1:0] HalfTurn = 17'sd32768;

  typedef enum logic [1:0] {
    KindCompose = 2'd0,
    KindDiff    = 2'd1,
    KindInverse = 2'd2,
    KindNone    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [PosW-1:0]  a_x;
    logic signed [PosW-1:0]  a_y;
    logic signed [HeadW-1:0] a_heading;
    logic signed [PosW-1:0]  b_x;
    logic signed [PosW-1:0]  b_y;
    logic signed [HeadW-1:0] b_heading;
  } in_beat_t;

  typedef struct packed {
    logic signed [PosW-1:0]  out_x;
    logic signed [PosW-1:0]  out_y;
    logic signed [HeadW-1:0] out_heading;
    logic                    saturated;
  } out_beat_t;

  // Payload handed from cell to cell.
  typedef struct packed {
    logic                    zero;
    logic signed [PosW-1:0]  off_x;
    logic signed [PosW-1:0]  off_y;
    logic signed [HeadW-1:0] heading;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } rot_t;

  // atan(2^-i) in units of pi / 2^31.
  function automatic logic signed [AngW-1:0] atan_lut(input logic [AtanIdxW-1:0] idx);
    logic signed [AngW-1:0] v;
    begin
      case (idx)
        5'd0:    v = 33'sd536870912;
        5'd1:    v = 33'sd316933406;
        5'd2:    v = 33'sd167458907;
        5'd3:    v = 33'sd85004756;
        5'd4:    v = 33'sd42667331;
        5'd5:    v = 33'sd21354465;
        5'd6:    v = 33'sd10680862;
        5'd7:    v = 33'sd5340245;
        5'd8:    v = 33'sd2670163;
        5'd9:    v = 33'sd1335087;
        5'd10:   v = 33'sd667544;
        5'd11:   v = 33'sd333772;
        5'd12:   v = 33'sd166886;
        5'd13:   v = 33'sd83443;
        5'd14:   v = 33'sd41721;
        5'd15:   v = 33'sd20860;
        5'd16:   v = 33'sd10430;
        5'd17:   v = 33'sd5215;
        5'd18:   v = 33'sd2607;
        5'd19:   v = 33'sd1303;
        5'd20:   v = 33'sd651;
        5'd21:   v = 33'sd325;
        5'd22:   v = 33'sd162;
        5'd23:   v = 33'sd81;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- design/ppc_prep.sv -----
module ppc_prep import ppc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     valid_o,
  output rot_t     rot_o
);

  // Operand selection.
  logic                     s1_valid_q;
  logic                     s1_zero_q, s1_zero_d;
  logic signed [PosW-1:0]   s1_off_x_q, s1_off_x_d, s1_off_y_q, s1_off_y_d;
  logic signed [HeadW-1:0]  s1_head_q, s1_head_d;
  logic signed [VecW-1:0]   s1_x_q, s1_x_d, s1_y_q, s1_y_d;
  logic signed [AngInW-1:0] s1_h_q, s1_h_d;

  always_comb begin
    s1_zero_d = 1'b0;
    s1_off_x_d = '0;
    s1_off_y_d = '0;
    s1_head_d = '0;
    s1_x_d = '0;
    s1_y_d = '0;
    s1_h_d = '0;
    case (kind_e'(beat_i.kind))
      KindCompose: begin
        s1_off_x_d = beat_i.a_x;
        s1_off_y_d = beat_i.a_y;
        s1_head_d = beat_i.a_heading + beat_i.b_heading;
        s1_x_d = VecW'(beat_i.b_x);
        s1_y_d = VecW'(beat_i.b_y);
        s1_h_d = AngInW'(beat_i.a_heading);
      end
      KindDiff: begin
        s1_head_d = beat_i.a_heading - beat_i.b_heading;
        s1_x_d = VecW'(beat_i.a_x) - VecW'(beat_i.b_x);
        s1_y_d = VecW'(beat_i.a_y) - VecW'(beat_i.b_y);
        s1_h_d = -AngInW'(beat_i.b_heading);
      end
      KindInverse: begin
        s1_head_d = -beat_i.a_heading;
        s1_x_d = -VecW'(beat_i.a_x);
        s1_y_d = -VecW'(beat_i.a_y);
        s1_h_d = -AngInW'(beat_i.a_heading);
      end
      default: begin
        s1_zero_d = 1'b1;
      end
    endcase
  end

  // Gain compensation: scale by K in Q30 and keep the guard bits.
  logic                     s2_valid_q;
  logic                     s2_zero_q;
  logic signed [PosW-1:0]   s2_off_x_q, s2_off_y_q;
  logic signed [HeadW-1:0]  s2_head_q;
  logic signed [AngInW-1:0] s2_h_q;
  logic signed [CordW-1:0]  s2_x_q, s2_x_d, s2_y_q, s2_y_d;
  logic signed [ProdW-1:0]  prod_x, prod_y;

  localparam logic signed [ProdW-1:0] GainHalf = ProdW'(1) <<< (GainShift - 1);

  always_comb begin
    prod_x = ProdW'(s1_x_q) * ProdW'(GainQ30) + GainHalf;
    prod_y = ProdW'(s1_y_q) * ProdW'(GainQ30) + GainHalf;
    s2_x_d = CordW'(prod_x >>> GainShift);
    s2_y_d = CordW'(prod_y >>> GainShift);
  end

  // Quadrant fold into +-pi/2, then the residual angle in pi/2^31 units.
  rot_t rot_q, rot_d;

  always_comb begin
    logic signed [AngInW-1:0] h;
    h = s2_h_q;
    rot_d.zero = s2_zero_q;
    rot_d.off_x = s2_off_x_q;
    rot_d.off_y = s2_off_y_q;
    rot_d.heading = s2_head_q;
    rot_d.x = s2_x_q;
    rot_d.y = s2_y_q;
    if (s2_h_q > QuarterTurn) begin
      h = s2_h_q - HalfTurn;
      rot_d.x = -s2_x_q;
      rot_d.y = -s2_y_q;
    end else if (s2_h_q < -QuarterTurn) begin
      h = s2_h_q + HalfTurn;
      rot_d.x = -s2_x_q;
      rot_d.y = -s2_y_q;
    end
    rot_d.z = {h[AngW-HeadW-1:0], {HeadW{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_zero_q <= s1_zero_d;
      s1_off_x_q <= s1_off_x_d;
      s1_off_y_q <= s1_off_y_d;
      s1_head_q <= s1_head_d;
      s1_x_q <= s1_x_d;
      s1_y_q <= s1_y_d;
      s1_h_q <= s1_h_d;
      s2_zero_q <= s1_zero_q;
      s2_off_x_q <= s1_off_x_q;
      s2_off_y_q <= s1_off_y_q;
      s2_head_q <= s1_head_q;
      s2_x_q <= s2_x_d;
      s2_y_q <= s2_y_d;
      s2_h_q <= s1_h_q;
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

// ----- design/ppc_cell.sv -----
module ppc_cell import ppc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [AtanIdxW-1:0] idx_i,
  input  logic                valid_i,
  input  rot_t                rot_i,
  output logic                valid_o,
  output rot_t                rot_o
);

  rot_t rot_q, rot_d;
  logic signed [CordW-1:0] dx, dy;

  // One micro-rotation: turn counterclockwise while the residual is not negative.
  always_comb begin
    dx = rot_i.y >>> idx_i;
    dy = rot_i.x >>> idx_i;
    rot_d = rot_i;
    if (!rot_i.z[AngW-1]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - atan_lut(idx_i);
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + atan_lut(idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

// ----- design/ppc_post.sv -----
module ppc_post import ppc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  rot_t      rot_i,
  output logic      valid_o,
  output out_beat_t beat_o
);

  localparam int RndW = CordW - GuardBits;
  localparam logic signed [CordW-1:0] RoundHalf = CordW'(1) <<< (GuardBits - 1);
  localparam logic signed [SumW-1:0] PosMax = SumW'(64'sh7FFF_FFFF);
  localparam logic signed [SumW-1:0] PosMin = -SumW'(64'sh8000_0000);

  // Drop the guard bits, rounding half up.
  logic                    r_valid_q;
  logic                    r_zero_q;
  logic signed [PosW-1:0]  r_off_x_q, r_off_y_q;
  logic signed [HeadW-1:0] r_head_q;
  logic signed [RndW-1:0]  r_x_q, r_x_d, r_y_q, r_y_d;

  logic signed [CordW-1:0] rnd_x, rnd_y;

  always_comb begin
    rnd_x = (rot_i.x + RoundHalf) >>> GuardBits;
    rnd_y = (rot_i.y + RoundHalf) >>> GuardBits;
    r_x_d = RndW'(rnd_x);
    r_y_d = RndW'(rnd_y);
  end

  // Add the offset and clip to the position range.
  out_beat_t beat_q, beat_d;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic sat_x, sat_y;

  always_comb begin
    sum_x = SumW'(r_x_q) + SumW'(r_off_x_q);
    sum_y = SumW'(r_y_q) + SumW'(r_off_y_q);
    sat_x = (sum_x > PosMax) || (sum_x < PosMin);
    sat_y = (sum_y > PosMax) || (sum_y < PosMin);
    beat_d.out_x = (sum_x > PosMax) ? PosW'(PosMax) :
                   (sum_x < PosMin) ? PosW'(PosMin) : PosW'(sum_x);
    beat_d.out_y = (sum_y > PosMax) ? PosW'(PosMax) :
                   (sum_y < PosMin) ? PosW'(PosMin) : PosW'(sum_y);
    beat_d.out_heading = r_head_q;
    beat_d.saturated = sat_x | sat_y;
    if (r_zero_q) begin
      beat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      r_valid_q <= valid_i;
      valid_o <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_zero_q <= rot_i.zero;
      r_off_x_q <= rot_i.off_x;
      r_off_y_q <= rot_i.off_y;
      r_head_q <= rot_i.heading;
      r_x_q <= r_x_d;
      r_y_q <= r_y_d;
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

// ----- design/planar_pose_compose.sv -----
// Planar pose arithmetic on a CORDIC rotator chain.
//
// Input channel: in_valid_i / in_stall_o / in_beat_i. A beat carries poses
// A and B and an operation code: compose, difference or inverse of A. An
// unused code yields a beat with every field zero.
// Output channel: out_valid_o / out_stall_i / out_beat_o. One result beat
// leaves for every input beat, in order.
//
// The pipeline has three setup stages (operand select, gain multiply,
// quadrant fold), one cell per micro-rotation (16), and two finishing stages
// (rounding, then offset add with saturation into the output register).
// Throughput is one beat per cycle unless stalled; each cell holds one beat.
//
// Reset clears every valid bit, so the pipeline comes up empty and ready.
// While the output register holds a beat and out_stall_i is high, the whole
// pipeline holds and in_stall_o rises in the same cycle; a free output
// register lets the chain advance even under stall.
module planar_pose_compose import ppc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  // Advance everything unless a finished beat waits on a stalled receiver.
  logic en;
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic chain_valid [NumStages+1];
  rot_t chain_rot [NumStages+1];

  ppc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .beat_i  (in_beat_i),
    .valid_o (chain_valid[0]),
    .rot_o   (chain_rot[0])
  );

  // One cell per micro-rotation; cell i shifts by i and uses atan(2^-i).
  for (genvar i = 0; i < NumStages; i++) begin : g_cell
    ppc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (AtanIdxW'(i)),
      .valid_i (chain_valid[i]),
      .rot_i   (chain_rot[i]),
      .valid_o (chain_valid[i+1]),
      .rot_o   (chain_rot[i+1])
    );
  end

  ppc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_valid[NumStages]),
    .rot_i   (chain_rot[NumStages]),
    .valid_o (out_valid_o),
    .beat_o  (out_beat_o)
  );

endmodule
